### rtl/tmos_pkg.sv
// Shared types and constants of the trimmed mean of samples unit.
package tmos_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int SAMPLE_COUNT_DEF = 50;
   localparam int TRIM_COUNT_DEF   = 10;
   localparam logic signed [SAMPLE_W-1:0] MIN_AVERAGE_RST = 16'sd200;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_PUT,
      ST_SUM_RD,
      ST_SUM_ADD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT
   } tmos_state_type;

   typedef struct packed {
      logic accept;
      logic rd;
      logic shift;
      logic put;
      logic sum_init;
      logic sum_add;
      logic div_start;
      logic load_out;
   } tmos_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic pos_zero;
      logic gt;
      logic last;
      logic sum_done;
      logic div_done;
      logic out_free;
   } tmos_sts_type;

endpackage

### rtl/tmos_div.sv
// Divide by a constant: signed dividend times a scaled reciprocal, quotient truncated toward zero.
module tmos_div #(
   parameter int SUM_W   = 22,
   parameter int DIVISOR = 30
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   output logic                    done,
   output logic signed [SUM_W-1:0] quotient
);

   localparam int     FRAC_W  = $clog2(DIVISOR);
   localparam int     SHIFT   = SUM_W + FRAC_W;
   localparam int     RECIP_W = SUM_W + 1;
   localparam int     PROD_W  = SUM_W + RECIP_W;
   localparam longint RECIP   =
      ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP);

   logic              done_ff, done_in;
   logic              neg_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]  mag;
   logic [SUM_W-1:0]  q_mag;

   assign mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
   assign done_in = start;
   assign q_mag   = SUM_W'(prod_ff >> SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= dividend[SUM_W-1];
         prod_ff <= PROD_W'(mag) * PROD_W'(RECIP_M);
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(q_mag) : $signed(q_mag);

endmodule

### rtl/tmos_datapath.sv
// Datapath: sample memory with insertion ordering, kept-range sum, divide and result register.
module tmos_datapath
   import tmos_pkg::*;
#(
   parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
   parameter int TRIM_COUNT   = TRIM_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  tmos_cmd_type        cmd,
   output tmos_sts_type        sts,
   input  logic [15:0]         req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,
   output logic                rsp_tuser,
   input  logic                csr_wen,
   input  logic [15:0]         csr_wdata
);

   localparam int ADDR_W   = $clog2(SAMPLE_COUNT);
   localparam int SUM_W    = SAMPLE_W + $clog2(SAMPLE_COUNT);
   localparam int KEPT     = SAMPLE_COUNT - 2 * TRIM_COUNT;
   localparam int KEPT_DIV = (KEPT > 0) ? KEPT : 1;
   localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(SAMPLE_COUNT - 1);
   localparam logic [ADDR_W-1:0] TRIM_IDX  = ADDR_W'(TRIM_COUNT);
   localparam logic [ADDR_W-1:0] KEEP_LAST = ADDR_W'(SAMPLE_COUNT - TRIM_COUNT - 1);

   logic signed [SAMPLE_W-1:0] store_mem [SAMPLE_COUNT];
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic signed [SAMPLE_W-1:0] key_ff;
   logic signed [SAMPLE_W-1:0] min_avg_ff;
   logic        [ADDR_W-1:0]   count_ff, count_in;
   logic        [ADDR_W-1:0]   pos_ff, pos_in;
   logic        [ADDR_W-1:0]   wr_addr;
   logic signed [SUM_W-1:0]    acc_ff;
   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] avg_ff;
   logic                       below_ff;
   logic signed [SAMPLE_W-1:0] avg_val;
   logic signed [SUM_W-1:0]    quotient;
   logic                       div_done;

   tmos_div #(
      .SUM_W   (SUM_W),
      .DIVISOR (KEPT_DIV)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign wr_addr = pos_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         store_mem[wr_addr] <= rd_ff;
      end else if (cmd.put) begin
         store_mem[wr_addr] <= key_ff;
      end
      if (cmd.rd) begin
         rd_ff <= store_mem[pos_ff];
      end
   end

   always_comb begin
      pos_in = pos_ff;
      priority if (cmd.accept) begin
         pos_in = count_ff - 1'b1;
      end else if (cmd.shift) begin
         pos_in = pos_ff - 1'b1;
      end else if (cmd.sum_init) begin
         pos_in = TRIM_IDX;
      end else if (cmd.sum_add) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.put) begin
         count_in = (count_ff == LAST_IDX) ? '0 : count_ff + 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign avg_val = (KEPT > 0) ? quotient[SAMPLE_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         min_avg_ff   <= MIN_AVERAGE_RST;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         if (csr_wen) begin
            min_avg_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.accept) begin
         key_ff <= req_tdata;
      end
      if (cmd.sum_init) begin
         acc_ff <= '0;
      end else if (cmd.sum_add) begin
         acc_ff <= acc_ff + SUM_W'(rd_ff);
      end
      if (cmd.load_out) begin
         avg_ff   <= avg_val;
         below_ff <= avg_val < min_avg_ff;
      end
   end

   assign sts.count_zero = count_ff == '0;
   assign sts.pos_zero   = pos_ff == '0;
   assign sts.gt         = rd_ff > key_ff;
   assign sts.last       = count_ff == LAST_IDX;
   assign sts.sum_done   = pos_ff == KEEP_LAST;
   assign sts.div_done   = div_done;
   assign sts.out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = avg_ff;
   assign rsp_tuser  = below_ff;

endmodule

### rtl/tmos_ctrl.sv
// Controller state machine sequencing insertion, summation, divide and result hand-off.
module tmos_ctrl
   import tmos_pkg::*;
#(
   parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
   parameter int TRIM_COUNT   = TRIM_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  tmos_sts_type sts,
   output tmos_cmd_type cmd
);

   localparam bit KEEP_ANY = (SAMPLE_COUNT - 2 * TRIM_COUNT) > 0;

   tmos_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = sts.count_zero ? ST_PUT : ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (sts.gt) begin
               cmd.shift = 1'b1;
               state_in  = sts.pos_zero ? ST_PUT : ST_READ;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            cmd.put = 1'b1;
            if (sts.last) begin
               cmd.sum_init = 1'b1;
               state_in     = KEEP_ANY ? ST_SUM_RD : ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SUM_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_SUM_ADD;
         end
         ST_SUM_ADD: begin
            cmd.sum_add = 1'b1;
            state_in    = sts.sum_done ? ST_DIV_GO : ST_SUM_RD;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/trimmed_mean_of_samples_unit.sv
// Each sample is compared with stored ones from the newest down, shifting each larger one up,
// until one is not larger or the bottom is met; it is written before the next is taken. The
// batch-closing sample adds a sum of the SAMPLE_COUNT - 2*TRIM_COUNT kept samples through the
// single memory read port, a reciprocal-multiply divide and an emit held while an older result
// waits. The result waits in an output register while the next batch streams in. Synchronous
// active-high reset clears batch count, controller, divider and output valid; min_average 200.
module trimmed_mean_of_samples_unit
   import tmos_pkg::*;
#(
   parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
   parameter int TRIM_COUNT   = TRIM_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] average
   output logic        rsp_tuser,   // [0] below_minimum
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata    // [15:0] min_average
);

   tmos_cmd_type cmd;
   tmos_sts_type sts;

   tmos_ctrl #(
      .SAMPLE_COUNT (SAMPLE_COUNT),
      .TRIM_COUNT   (TRIM_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tmos_datapath #(
      .SAMPLE_COUNT (SAMPLE_COUNT),
      .TRIM_COUNT   (TRIM_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

endmodule
